/* rtl/core/tcd_pkg.sv */
// ----------------------------------------------------------------------------
// tcd_pkg: shared types and constants of the typewriter code decoder
// Code points, glyph tables, reset values and the per-code result struct.
// ----------------------------------------------------------------------------
package tcd_pkg;

  localparam int unsigned COL_W       = 8;
  localparam int unsigned CODE_W      = 6;
  localparam int unsigned GLYPH_W     = 8;
  localparam int unsigned PCOL_W      = 7;
  localparam int unsigned TAB_PITCH_DEF = 8;

  localparam logic [COL_W-1:0] LINE_WIDTH_RST = 8'd80;
  localparam logic [COL_W-1:0] WIDTH_MIN      = 8'd1;
  localparam logic [COL_W-1:0] WIDTH_MAX      = 8'd128;
  localparam logic [COL_W-1:0] COL_SAT        = 8'd255;

  // Control codes (octal, as on the typewriter)
  localparam logic [CODE_W-1:0] CODE_COLOUR    = 6'o20;
  localparam logic [CODE_W-1:0] CODE_BACKSPACE = 6'o43;
  localparam logic [CODE_W-1:0] CODE_TAB       = 6'o45;
  localparam logic [CODE_W-1:0] CODE_RETURN    = 6'o51;
  localparam logic [CODE_W-1:0] CODE_STOP      = 6'o61;
  localparam logic [CODE_W-1:0] CODE_UPPER     = 6'o71;
  localparam logic [CODE_W-1:0] CODE_LOWER     = 6'o75;
  localparam logic [CODE_W-1:0] CODE_DELETE    = 6'o77;

  localparam logic [GLYPH_W-1:0] GLYPH_LOWER [64] = '{
    8'h00, 8'h00, 8'h65, 8'h38, 8'h00, 8'h7C, 8'h61, 8'h33,
    8'h20, 8'h3D, 8'h73, 8'h34, 8'h69, 8'h2B, 8'h75, 8'h32,
    8'h00, 8'h2E, 8'h64, 8'h35, 8'h72, 8'h31, 8'h6A, 8'h37,
    8'h6E, 8'h2C, 8'h66, 8'h36, 8'h63, 8'h2D, 8'h6B, 8'h00,
    8'h74, 8'h00, 8'h7A, 8'h00, 8'h6C, 8'h00, 8'h77, 8'h00,
    8'h68, 8'h00, 8'h79, 8'h00, 8'h70, 8'h00, 8'h71, 8'h00,
    8'h6F, 8'h00, 8'h62, 8'h00, 8'h67, 8'h00, 8'h39, 8'h00,
    8'h6D, 8'h00, 8'h78, 8'h00, 8'h76, 8'h00, 8'h30, 8'h00
  };

  localparam logic [GLYPH_W-1:0] GLYPH_UPPER [64] = '{
    8'h00, 8'h00, 8'h45, 8'h88, 8'h00, 8'h5F, 8'h41, 8'h83,
    8'h20, 8'h3A, 8'h53, 8'h84, 8'h49, 8'h2F, 8'h55, 8'h82,
    8'h00, 8'h29, 8'h44, 8'h85, 8'h52, 8'h81, 8'h4A, 8'h87,
    8'h4E, 8'h28, 8'h46, 8'h86, 8'h43, 8'h8A, 8'h4B, 8'h00,
    8'h54, 8'h00, 8'h5A, 8'h00, 8'h4C, 8'h00, 8'h57, 8'h00,
    8'h48, 8'h00, 8'h59, 8'h00, 8'h50, 8'h00, 8'h51, 8'h00,
    8'h4F, 8'h00, 8'h42, 8'h00, 8'h47, 8'h00, 8'h89, 8'h00,
    8'h4D, 8'h00, 8'h58, 8'h00, 8'h56, 8'h00, 8'h80, 8'h00
  };

  typedef struct packed {
    logic               print_valid;
    logic [GLYPH_W-1:0] glyph;
    logic [PCOL_W-1:0]  print_column;
    logic               line_feed;
    logic               upper_case;
    logic [COL_W-1:0]   column_after;
  } result_t;

endpackage

/* rtl/core/tcd_carriage.sv */
// ----------------------------------------------------------------------------
// tcd_carriage: carriage column and case shift state with per-code decode
// Decodes one code against the current state; state moves on step_i.
// ----------------------------------------------------------------------------
module tcd_carriage #(
  parameter int unsigned TAB_PITCH = tcd_pkg::TAB_PITCH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [tcd_pkg::CODE_W-1:0]  code_i,
  input  logic [tcd_pkg::COL_W-1:0]   line_width_i,
  output tcd_pkg::result_t            result_o
);

  localparam int unsigned SumW = tcd_pkg::COL_W + 1;
  localparam int unsigned ColDepth = 2 ** tcd_pkg::COL_W;

  logic [tcd_pkg::COL_W-1:0] column_q, column_d;
  logic                      shift_q, shift_d;
  logic [tcd_pkg::COL_W-1:0] eff_width;
  logic [tcd_pkg::COL_W-1:0] print_base;
  logic [SumW-1:0]           tab_next;
  logic [SumW-1:0]           tab_lut [ColDepth];

  // Next tab stop per column, folded to constants
  for (genvar i = 0; i < ColDepth; i++) begin : g_tab
    assign tab_lut[i] = SumW'(i + TAB_PITCH - (i % TAB_PITCH));
  end

  assign tab_next = tab_lut[column_q];

  always_comb begin
    if (line_width_i == '0) begin
      eff_width = tcd_pkg::WIDTH_MIN;
    end else if (line_width_i > tcd_pkg::WIDTH_MAX) begin
      eff_width = tcd_pkg::WIDTH_MAX;
    end else begin
      eff_width = line_width_i;
    end
  end

  always_comb begin
    column_d   = column_q;
    shift_d    = shift_q;
    print_base = '0;
    result_o   = '0;
    case (code_i)
      tcd_pkg::CODE_COLOUR, tcd_pkg::CODE_STOP, tcd_pkg::CODE_DELETE: begin
      end
      tcd_pkg::CODE_BACKSPACE: begin
        if (column_q != '0) begin
          column_d = column_q - 1'b1;
        end
      end
      tcd_pkg::CODE_TAB: begin
        if (tab_next > SumW'(tcd_pkg::COL_SAT)) begin
          column_d = tcd_pkg::COL_SAT;
        end else begin
          column_d = tab_next[tcd_pkg::COL_W-1:0];
        end
      end
      tcd_pkg::CODE_RETURN: begin
        column_d           = '0;
        result_o.line_feed = 1'b1;
      end
      tcd_pkg::CODE_UPPER: begin
        shift_d = 1'b1;
      end
      tcd_pkg::CODE_LOWER: begin
        shift_d = 1'b0;
      end
      default: begin
        // wrap first, so the print column stays below the line width
        if (column_q >= eff_width) begin
          result_o.line_feed = 1'b1;
        end else begin
          print_base = column_q;
        end
        result_o.print_valid  = 1'b1;
        result_o.glyph        = shift_q ? tcd_pkg::GLYPH_UPPER[code_i]
                                        : tcd_pkg::GLYPH_LOWER[code_i];
        result_o.print_column = print_base[tcd_pkg::PCOL_W-1:0];
        column_d              = print_base + 1'b1;
      end
    endcase
    result_o.upper_case   = shift_d;
    result_o.column_after = column_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q <= '0;
      shift_q  <= 1'b0;
    end else if (step_i) begin
      column_q <= column_d;
      shift_q  <= shift_d;
    end
  end

endmodule

/* rtl/core/typewriter_code_decoder.sv */
// ----------------------------------------------------------------------------
// typewriter_code_decoder: six-bit typewriter code to glyph and carriage moves
// Input register, carriage decode, result register; one code per cycle while results are taken.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / code_i) takes one code per beat.
//   Output channel (out_valid_o / out_ready_i) returns exactly one result
//   beat per code, in order: print_valid_o, glyph_o, print_column_o,
//   line_feed_o, upper_case_o, column_after_o.
//   Config channel (cfg_valid_i / cfg_ready_o / cfg_line_width_i) writes the
//   line width; it is always ready and must only be used while idle.
// Path: a code accepted on the input channel lands in the input register,
//   is decoded into the result register when that register is free or
//   being drained, and is then offered on the output channel.
// Throughput: one code per cycle while the receiver takes results, through
//   the single decode stage between the input and result registers; carriage
//   state updates as each code moves into the result register.
// Reset: column 0, lower case, line width 80, both registers empty.
// Stall: while the result is not taken, one more code may wait in the input
//   register; after that in_ready_o drops until the receiver takes a beat.
// ----------------------------------------------------------------------------
module typewriter_code_decoder #(
  parameter int unsigned TAB_PITCH = tcd_pkg::TAB_PITCH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tcd_pkg::COL_W-1:0]     cfg_line_width_i,
  // code channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tcd_pkg::CODE_W-1:0]    code_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          print_valid_o,
  output logic [tcd_pkg::GLYPH_W-1:0]   glyph_o,
  output logic [tcd_pkg::PCOL_W-1:0]    print_column_o,
  output logic                          line_feed_o,
  output logic                          upper_case_o,
  output logic [tcd_pkg::COL_W-1:0]     column_after_o
);

  logic                        in_valid_q;
  logic [tcd_pkg::CODE_W-1:0]  code_q;
  logic                        out_valid_q;
  tcd_pkg::result_t            result_q, result_d;
  logic [tcd_pkg::COL_W-1:0]   line_width_q;
  logic                        advance;

  // config: always accepted; only written while idle is a rule the user keeps, the block does not enforce it
  assign cfg_ready_o = 1'b1;

  // a code moves on when the result register is free or is being drained
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  tcd_carriage #(
    .TAB_PITCH(TAB_PITCH)
  ) u_carriage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .code_i      (code_q),
    .line_width_i(line_width_q),
    .result_o    (result_d)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      line_width_q <= tcd_pkg::LINE_WIDTH_RST;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        line_width_q <= cfg_line_width_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      code_q <= code_i;
    end
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign print_valid_o  = result_q.print_valid;
  assign glyph_o        = result_q.glyph;
  assign print_column_o = result_q.print_column;
  assign line_feed_o    = result_q.line_feed;
  assign upper_case_o   = result_q.upper_case;
  assign column_after_o = result_q.column_after;

endmodule

/* rtl/core/tcd_checker.sv */
// ----------------------------------------------------------------------------
// tcd_checker: port-level checks of the typewriter code decoder
// Result consistency and output hold under stall, bound to the top level.
// ----------------------------------------------------------------------------
module tcd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic                        print_valid_o,
  input logic [tcd_pkg::GLYPH_W-1:0] glyph_o,
  input logic [tcd_pkg::PCOL_W-1:0]  print_column_o,
  input logic                        line_feed_o,
  input logic [tcd_pkg::COL_W-1:0]   column_after_o
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(glyph_o)
      && $stable(column_after_o) && $stable(print_valid_o))
    else $error("result beat changed while stalled");

  // non-printing codes carry no glyph and no print column
  a_no_print: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !print_valid_o |-> glyph_o == '0 && print_column_o == '0)
    else $error("glyph or column on non-printing beat");

  // printing advances the carriage by one past the print column
  a_print_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && print_valid_o |->
      column_after_o == {1'b0, print_column_o} + 1'b1)
    else $error("column did not advance after print");

  // a line feed returns the carriage to the left margin; a wrapped print lands there
  a_lf_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_feed_o |->
      print_column_o == '0 && (print_valid_o || column_after_o == '0))
    else $error("line feed without return to margin");

endmodule

bind typewriter_code_decoder tcd_checker u_tcd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .print_valid_o (print_valid_o),
  .glyph_o       (glyph_o),
  .print_column_o(print_column_o),
  .line_feed_o   (line_feed_o),
  .column_after_o(column_after_o)
);
